// ===== src/trtq_pkg.sv =====
// Shared types and constants for the thread ready-time queue.
// No dependencies; imported by trtq_cell, thread_ready_time_queue_core and tb_top.
package trtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 8;
  localparam int TIME_BITS_DEF   = 32;
  localparam int MODE_W          = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND  = 3'd0,
    MODE_SORTED  = 3'd1,
    MODE_POP     = 3'd2,
    MODE_CUR_1ST = 3'd3,
    MODE_CUR_NXT = 3'd4,
    MODE_REPORT  = 3'd5
  } mode_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic ins;       // insert (append or sorted), queue not full
    logic sorted;    // insert position chosen by ready time
    logic pop;       // remove head, queue not empty
    logic cur_move;  // cursor first or cursor next
  } cell_cmd_t;

endpackage

// ===== src/trtq_cell.sv =====
// One slot of the queue row: valid bit, tag, ready time and cursor mark.
// Depends on trtq_pkg; instantiated in a chain by thread_ready_time_queue_core.
module trtq_cell
  import trtq_pkg::*;
#(
  parameter int TAG_BITS  = TAG_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_cmd_t            cmd,
  input  logic [TAG_BITS-1:0]  new_tag,
  input  logic [TIME_BITS-1:0] new_time,
  // left neighbor (toward head)
  input  logic                 left_valid,
  input  logic [TAG_BITS-1:0]  left_tag,
  input  logic [TIME_BITS-1:0] left_time,
  input  logic                 left_mark,
  // right neighbor (toward tail)
  input  logic                 right_valid,
  input  logic [TAG_BITS-1:0]  right_tag,
  input  logic [TIME_BITS-1:0] right_time,
  input  logic                 right_mark,
  // insert position found ahead of this cell (found_in) or at or ahead of it (found_out)
  input  logic                 found_in,
  output logic                 found_out,
  output logic                 valid_q,
  output logic [TAG_BITS-1:0]  tag_q,
  output logic [TIME_BITS-1:0] time_q,
  output logic                 mark_q
);

  logic                 valid_r, valid_nxt;
  logic                 mark_r, mark_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic                 hit;
  logic                 sel;

  // first empty slot or first strictly later entry takes the new word
  assign hit       = valid_r & cmd.sorted & (new_time < time_r);
  assign sel       = hit | ~valid_r;
  assign found_out = found_in | sel;

  always_comb begin
    valid_nxt = valid_r;
    mark_nxt  = mark_r;
    tag_nxt   = tag_r;
    time_nxt  = time_r;
    if (cmd.ins) begin
      if (found_in) begin
        valid_nxt = left_valid;
        mark_nxt  = left_mark;
        tag_nxt   = left_tag;
        time_nxt  = left_time;
      end else if (sel) begin
        valid_nxt = 1'b1;
        mark_nxt  = 1'b0;
        tag_nxt   = new_tag;
        time_nxt  = new_time;
      end
    end else if (cmd.pop) begin
      valid_nxt = right_valid;
      mark_nxt  = right_mark;
      tag_nxt   = right_tag;
      time_nxt  = right_time;
    end else if (cmd.cur_move) begin
      mark_nxt = left_mark & valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      mark_r  <= mark_nxt;
    end
    tag_r  <= tag_nxt;
    time_r <= time_nxt;
  end

  assign valid_q = valid_r;
  assign tag_q   = tag_r;
  assign time_q  = time_r;
  assign mark_q  = mark_r;

endmodule

// ===== src/thread_ready_time_queue_core.sv =====
// Thread ready-time queue: a row of trtq_cell slots with a walking cursor.
// Depends on trtq_pkg and trtq_cell.
//
// One command word is taken on every cycle in which start is high; busy is never
// raised. Its result appears on the out_ ports with out_valid high in the cycle
// after the command is taken, for exactly one cycle, and the receiver cannot
// stall it. All slots update together on the edge that takes the command; the
// critical path runs through the insert-position flag that ripples along the row
// of cells and the ready-time compare in each cell. The cursor is a mark carried
// by the slot it sits on, so it follows its entry through inserts and pops.
module thread_ready_time_queue_core
  import trtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [TAG_BITS-1:0]  in_thread_tag,
  input  logic [TIME_BITS-1:0] in_ready_time,
  output logic                 out_valid,
  output logic [TAG_BITS-1:0]  out_popped_tag,
  output logic                 out_popped_valid,
  output logic                 out_insert_dropped,
  output logic [CNT_W-1:0]     out_entry_count,
  output logic [TAG_BITS-1:0]  out_head_tag,
  output logic                 out_head_valid,
  output logic [TAG_BITS-1:0]  out_cursor_tag,
  output logic                 out_cursor_valid
);

  logic                 accept;
  cell_cmd_t            cmd;
  logic                 full;
  logic                 is_ins;
  logic                 dropped;

  logic [QUEUE_DEPTH-1:0] valid_v;
  logic [QUEUE_DEPTH-1:0] mark_v;
  logic [QUEUE_DEPTH-1:0] found_v;
  logic [QUEUE_DEPTH-1:0] left_mark_v;
  logic [TAG_BITS-1:0]    tag_a  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]   time_a [QUEUE_DEPTH];

  logic                 before_first_r, before_first_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 strobe_r;
  logic [TAG_BITS-1:0]  popped_tag_r, popped_tag_nxt;
  logic                 popped_valid_r;
  logic                 dropped_r;
  logic [TAG_BITS-1:0]  cursor_tag;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign full   = valid_v[QUEUE_DEPTH-1];

  // mode decode
  always_comb begin
    is_ins         = 1'b0;
    cmd            = '0;
    popped_tag_nxt = '0;
    unique case (mode_t'(in_mode))
      MODE_APPEND, MODE_SORTED: begin
        is_ins     = 1'b1;
        cmd.ins    = accept & ~full;
        cmd.sorted = (mode_t'(in_mode) == MODE_SORTED);
      end
      MODE_POP: begin
        cmd.pop = accept & valid_v[0];
        if (valid_v[0]) begin
          popped_tag_nxt = tag_a[0];
        end
      end
      MODE_CUR_1ST, MODE_CUR_NXT: begin
        cmd.cur_move = accept;
      end
      default: begin
      end
    endcase
  end

  assign dropped = is_ins & full;

  // mark seen by each cell from its left: cursor first seeds the head only
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == 0) begin
        left_mark_v[i] = (mode_t'(in_mode) == MODE_CUR_1ST) | before_first_r;
      end else begin
        left_mark_v[i] = (mode_t'(in_mode) == MODE_CUR_1ST) ? 1'b0 : mark_v[i-1];
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                 l_valid, r_valid, r_mark, f_in;
    logic [TAG_BITS-1:0]  l_tag, r_tag;
    logic [TIME_BITS-1:0] l_time, r_time;

    if (g == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_tag   = '0;
      assign l_time  = '0;
      assign f_in    = 1'b0;
    end else begin : g_mid_l
      assign l_valid = valid_v[g-1];
      assign l_tag   = tag_a[g-1];
      assign l_time  = time_a[g-1];
      assign f_in    = found_v[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_mark  = 1'b0;
      assign r_tag   = '0;
      assign r_time  = '0;
    end else begin : g_mid_r
      assign r_valid = valid_v[g+1];
      assign r_mark  = mark_v[g+1];
      assign r_tag   = tag_a[g+1];
      assign r_time  = time_a[g+1];
    end

    trtq_cell #(
      .TAG_BITS  (TAG_BITS),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .new_tag     (in_thread_tag),
      .new_time    (in_ready_time),
      .left_valid  (l_valid),
      .left_tag    (l_tag),
      .left_time   (l_time),
      .left_mark   (left_mark_v[g]),
      .right_valid (r_valid),
      .right_tag   (r_tag),
      .right_time  (r_time),
      .right_mark  (r_mark),
      .found_in    (f_in),
      .found_out   (found_v[g]),
      .valid_q     (valid_v[g]),
      .tag_q       (tag_a[g]),
      .time_q      (time_a[g]),
      .mark_q      (mark_v[g])
    );
  end

  always_comb begin
    before_first_nxt = before_first_r;
    count_nxt        = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
      // cursor on the popped head parks before the new head
      if (mark_v[0]) begin
        before_first_nxt = 1'b1;
      end
    end else if (cmd.cur_move) begin
      before_first_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      before_first_r <= 1'b0;
      count_r        <= '0;
      strobe_r       <= 1'b0;
      popped_valid_r <= 1'b0;
      dropped_r      <= 1'b0;
    end else begin
      before_first_r <= before_first_nxt;
      count_r        <= count_nxt;
      strobe_r       <= accept;
      popped_valid_r <= cmd.pop;
      dropped_r      <= accept & dropped;
    end
    popped_tag_r <= popped_tag_nxt;
  end

  // at most one mark is set, so an OR over the row selects its tag
  always_comb begin
    cursor_tag = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cursor_tag = cursor_tag | (tag_a[i] & {TAG_BITS{mark_v[i]}});
    end
  end

  assign out_valid          = strobe_r;
  assign out_popped_tag     = popped_tag_r;
  assign out_popped_valid   = popped_valid_r;
  assign out_insert_dropped = dropped_r;
  assign out_entry_count    = count_r;
  assign out_head_tag       = valid_v[0] ? tag_a[0] : '0;
  assign out_head_valid     = valid_v[0];
  assign out_cursor_tag     = cursor_tag;
  assign out_cursor_valid   = |mark_v;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_v)))
    else $error("entry count disagrees with occupied cells");

  a_cursor_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(mark_v))
    else $error("cursor mark on more than one cell");

  a_mark_on_live: assert property (@(posedge clk) disable iff (!rst_n)
    (mark_v & ~valid_v) == '0)
    else $error("cursor mark on an empty cell");

  a_before_first_no_mark: assert property (@(posedge clk) disable iff (!rst_n)
    before_first_r |-> (mark_v == '0))
    else $error("cursor both before first and on an entry");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted command without result word");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for thread_ready_time_queue_core: directed table, then random words.
// Depends on trtq_pkg and the core RTL; results are checked against an in-bench queue model or typed table reports.
`timescale 1ns / 1ps

module tb_top;
  import trtq_pkg::*;

  localparam int CNT_W        = $clog2(QUEUE_DEPTH_DEF + 1);
  localparam int CUR_PAST_END = QUEUE_DEPTH_DEF;
  localparam int CUR_BEFORE   = QUEUE_DEPTH_DEF + 1;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int WORDS_PER_PHASE = 480;

  // undefined mode codes, which the core treats as report
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [TAG_BITS_DEF-1:0] popped_tag;
    logic                    popped_valid;
    logic                    insert_dropped;
    logic [CNT_W-1:0]        entry_count;
    logic [TAG_BITS_DEF-1:0] head_tag;
    logic                    head_valid;
    logic [TAG_BITS_DEF-1:0] cursor_tag;
    logic                    cursor_valid;
  } queue_report_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [TAG_BITS_DEF-1:0]  tag;
    logic [TIME_BITS_DEF-1:0] rtime;
    logic [4:0]               reps;
    logic                     typed;
    queue_report_t            report;
  } dir_row_t;

  localparam queue_report_t RPT_IDLE   = '0;
  localparam queue_report_t RPT_FIRST  = '{8'h00, 1'b0, 1'b0, 5'd1, 8'hFF, 1'b1, 8'h00, 1'b0};
  localparam queue_report_t RPT_SECOND = '{8'h00, 1'b0, 1'b0, 5'd2, 8'h00, 1'b1, 8'h00, 1'b0};
  localparam queue_report_t RPT_FULL   = '{8'h00, 1'b0, 1'b1, 5'd16, 8'hFF, 1'b1, 8'h00, 1'b0};

  dir_row_t dir_rows [22] = '{
    '{MODE_REPORT,  8'h00, 32'h0000_0000, 5'd1,  1'b1, RPT_IDLE},
    '{MODE_POP,     8'h00, 32'h0000_0000, 5'd1,  1'b1, RPT_IDLE},
    '{MODE_CUR_1ST, 8'h00, 32'h0000_0000, 5'd1,  1'b1, RPT_IDLE},
    '{MODE_CUR_NXT, 8'h00, 32'h0000_0000, 5'd1,  1'b1, RPT_IDLE},
    '{MODE_APPEND,  8'hFF, 32'hFFFF_FFFF, 5'd1,  1'b1, RPT_FIRST},
    '{MODE_SORTED,  8'h00, 32'h0000_0000, 5'd1,  1'b1, RPT_SECOND},
    '{MODE_SORTED,  8'h11, 32'hFFFF_FFFF, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_SORTED,  8'h22, 32'h8000_0000, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_CUR_1ST, 8'h00, 32'h0000_0000, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_CUR_NXT, 8'h00, 32'h0000_0000, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_SORTED,  8'h33, 32'h0000_0005, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_POP,     8'h00, 32'h0000_0000, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_POP,     8'h00, 32'h0000_0000, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_POP,     8'h00, 32'h0000_0000, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_CUR_NXT, 8'h00, 32'h0000_0000, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_SPARE_6, 8'hFF, 32'hFFFF_FFFF, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_SPARE_7, 8'hFF, 32'hFFFF_FFFF, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_CUR_NXT, 8'h00, 32'h0000_0000, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_CUR_NXT, 8'h00, 32'h0000_0000, 5'd1,  1'b0, RPT_IDLE},
    '{MODE_APPEND,  8'hA5, 32'h5A5A_5A5A, 5'd14, 1'b0, RPT_IDLE},
    '{MODE_SORTED,  8'h3C, 32'h0000_0000, 5'd1,  1'b1, RPT_FULL},
    '{MODE_APPEND,  8'hC3, 32'hFFFF_FFFF, 5'd1,  1'b1, RPT_FULL}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [MODE_W-1:0]        in_mode;
  logic [TAG_BITS_DEF-1:0]  in_thread_tag;
  logic [TIME_BITS_DEF-1:0] in_ready_time;
  logic                     out_valid;
  logic [TAG_BITS_DEF-1:0]  out_popped_tag;
  logic                     out_popped_valid;
  logic                     out_insert_dropped;
  logic [CNT_W-1:0]         out_entry_count;
  logic [TAG_BITS_DEF-1:0]  out_head_tag;
  logic                     out_head_valid;
  logic [TAG_BITS_DEF-1:0]  out_cursor_tag;
  logic                     out_cursor_valid;

  thread_ready_time_queue_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_thread_tag      (in_thread_tag),
    .in_ready_time      (in_ready_time),
    .out_valid          (out_valid),
    .out_popped_tag     (out_popped_tag),
    .out_popped_valid   (out_popped_valid),
    .out_insert_dropped (out_insert_dropped),
    .out_entry_count    (out_entry_count),
    .out_head_tag       (out_head_tag),
    .out_head_valid     (out_head_valid),
    .out_cursor_tag     (out_cursor_tag),
    .out_cursor_valid   (out_cursor_valid)
  );

  // queue model
  logic [TIME_BITS_DEF-1:0] sched_time [QUEUE_DEPTH_DEF];
  logic [TAG_BITS_DEF-1:0]  sched_tag  [QUEUE_DEPTH_DEF];
  int                       sched_count;
  int                       sched_cursor;

  queue_report_t pending_reports [$];
  int            err_count;
  int            cycle_count;
  bit            word_taken;
  int            send_idle_pct;
  bit            row_typed;
  queue_report_t row_report;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic queue_model_step(input logic [MODE_W-1:0] m,
                                  input logic [TAG_BITS_DEF-1:0] tag,
                                  input logic [TIME_BITS_DEF-1:0] t,
                                  output queue_report_t rep);
    int pos;
    int k;
    rep = '0;
    case (m)
      MODE_APPEND, MODE_SORTED: begin
        if (sched_count >= QUEUE_DEPTH_DEF) begin
          rep.insert_dropped = 1'b1;
        end else begin
          pos = sched_count;
          // scan downward so pos ends on the first strictly later entry
          if (m == MODE_SORTED) begin
            for (k = sched_count - 1; k >= 0; k--) begin
              if (t < sched_time[k]) pos = k;
            end
          end
          for (k = sched_count; k > pos; k--) begin
            sched_time[k] = sched_time[k-1];
            sched_tag[k]  = sched_tag[k-1];
          end
          sched_time[pos] = t;
          sched_tag[pos]  = tag;
          sched_count++;
          if (sched_cursor < CUR_PAST_END && sched_cursor >= pos) sched_cursor++;
        end
      end
      MODE_POP: begin
        if (sched_count > 0) begin
          rep.popped_tag   = sched_tag[0];
          rep.popped_valid = 1'b1;
          for (k = 1; k < sched_count; k++) begin
            sched_time[k-1] = sched_time[k];
            sched_tag[k-1]  = sched_tag[k];
          end
          sched_count--;
          if (sched_cursor == 0) sched_cursor = CUR_BEFORE;
          else if (sched_cursor < CUR_PAST_END) sched_cursor--;
        end
      end
      MODE_CUR_1ST: sched_cursor = (sched_count > 0) ? 0 : CUR_PAST_END;
      MODE_CUR_NXT: begin
        if (sched_cursor == CUR_BEFORE) begin
          sched_cursor = (sched_count > 0) ? 0 : CUR_PAST_END;
        end else if (sched_cursor < CUR_PAST_END) begin
          sched_cursor = (sched_cursor + 1 < sched_count) ? sched_cursor + 1 : CUR_PAST_END;
        end
      end
      default: ;
    endcase
    rep.entry_count = CNT_W'(sched_count);
    if (sched_count > 0) begin
      rep.head_tag   = sched_tag[0];
      rep.head_valid = 1'b1;
    end
    if (sched_cursor < sched_count) begin
      rep.cursor_tag   = sched_tag[sched_cursor];
      rep.cursor_valid = 1'b1;
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // compare results first, then take the word of this edge into the model
  always @(posedge clk) begin
    queue_report_t want;
    queue_report_t fresh;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (pending_reports.size() == 0) begin
          err_count++;
          $display("%0t: result word with nothing expected, actual count %0h",
                   $time, out_entry_count);
        end else begin
          want = pending_reports.pop_front();
          check_field("popped_tag",     32'(want.popped_tag),     32'(out_popped_tag));
          check_field("popped_valid",   32'(want.popped_valid),   32'(out_popped_valid));
          check_field("insert_dropped", 32'(want.insert_dropped), 32'(out_insert_dropped));
          check_field("entry_count",    32'(want.entry_count),    32'(out_entry_count));
          check_field("head_tag",       32'(want.head_tag),       32'(out_head_tag));
          check_field("head_valid",     32'(want.head_valid),     32'(out_head_valid));
          check_field("cursor_tag",     32'(want.cursor_tag),     32'(out_cursor_tag));
          check_field("cursor_valid",   32'(want.cursor_valid),   32'(out_cursor_valid));
        end
      end
      word_taken = start && !busy;
      if (word_taken) begin
        queue_model_step(in_mode, in_thread_tag, in_ready_time, fresh);
        pending_reports.push_back(row_typed ? row_report : fresh);
      end
    end else begin
      word_taken = 1'b0;
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic issue_word(input logic [MODE_W-1:0] m, input logic [TAG_BITS_DEF-1:0] tag,
                            input logic [TIME_BITS_DEF-1:0] t, input bit typed,
                            input queue_report_t rep);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_mode       <= m;
    in_thread_tag <= tag;
    in_ready_time <= t;
    row_typed  = typed;
    row_report = rep;
    @(negedge clk);
    while (!word_taken) @(negedge clk);
  endtask

  initial begin
    logic [MODE_W-1:0]        m;
    logic [TAG_BITS_DEF-1:0]  tag;
    logic [TIME_BITS_DEF-1:0] t;
    int                       r;
    int                       ph;
    int                       n;
    int                       tide_left;
    bit                       filling;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_mode       = MODE_REPORT;
    in_thread_tag = '0;
    in_ready_time = '0;
    row_typed     = 1'b0;
    row_report    = '0;
    word_taken    = 1'b0;
    err_count     = 0;
    cycle_count   = 0;
    send_idle_pct = 32;
    sched_count   = 0;
    sched_cursor  = CUR_PAST_END;
    filling       = 1'b1;
    tide_left     = 40;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      for (n = 0; n < dir_rows[i].reps; n++) begin
        issue_word(dir_rows[i].mode, dir_rows[i].tag, dir_rows[i].rtime,
                   dir_rows[i].typed, dir_rows[i].report);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 83 : 0;
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        // alternate fill-heavy and drain-heavy stretches to reach full and empty
        if (tide_left == 0) begin
          filling   = !filling;
          tide_left = $urandom_range(60, 20);
        end
        tide_left--;
        r = $urandom_range(99);
        if (r < (filling ? 35 : 12))      m = MODE_SORTED;
        else if (r < (filling ? 55 : 22)) m = MODE_APPEND;
        else if (r < (filling ? 68 : 68)) m = MODE_POP;
        else if (r < 78)                  m = MODE_CUR_1ST;
        else if (r < 92)                  m = MODE_CUR_NXT;
        else if (r < 97)                  m = MODE_REPORT;
        else                              m = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
        tag = TAG_BITS_DEF'($urandom_range(255));
        // favor repeated keys so equal-time ordering gets exercised
        case ($urandom_range(3))
          0:       t = TIME_BITS_DEF'($urandom_range(7));
          1:       t = $urandom_range(1) ? '1 : '0;
          2:       t = TIME_BITS_DEF'($urandom);
          default: t = TIME_BITS_DEF'($urandom_range(15)) << 28;
        endcase
        issue_word(m, tag, t, 1'b0, RPT_IDLE);
      end
    end
    start <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/trtq_pkg.sv
src/trtq_cell.sv
src/thread_ready_time_queue_core.sv
bench/tb_top.sv
